// ----- rtl/core/pee_pkg.sv -----
package pee_pkg;

   localparam logic [7:0] CHAR_ZERO  = 8'h30;
   localparam logic [7:0] CHAR_NINE  = 8'h39;
   localparam logic [7:0] CHAR_ADD   = 8'h2B;
   localparam logic [7:0] CHAR_SUB   = 8'h2D;
   localparam logic [7:0] CHAR_MUL   = 8'h2A;
   localparam logic [7:0] CHAR_DIV   = 8'h2F;
   localparam logic [7:0] CHAR_REM   = 8'h25;
   localparam logic [7:0] CHAR_POW   = 8'h5E;

   localparam logic [2:0] ST_OK        = 3'd0;
   localparam logic [2:0] ST_OVERFLOW  = 3'd1;
   localparam logic [2:0] ST_UNDERFLOW = 3'd2;
   localparam logic [2:0] ST_ZERODIV   = 3'd3;
   localparam logic [2:0] ST_INVALID   = 3'd4;

   typedef enum logic [2:0] {
      OP_ADD,
      OP_SUB,
      OP_MUL,
      OP_DIV,
      OP_REM,
      OP_POW
   } op_type;

   typedef enum logic [2:0] {
      S_IDLE,
      S_RD_B,
      S_RD_A,
      S_EXEC,
      S_WAIT,
      S_RD_WAIT,
      S_RD_TOP,
      S_RESP
   } state_type;

   // Handshake between the sequencer and the arithmetic unit.
   typedef struct packed {
      logic   start;
      op_type op;
   } alu_ctl_type;

endpackage

// ----- rtl/core/pee_alu.sv -----
// Iterative arithmetic unit: one add or subtract, a 32x32 multiply, a restoring
// divide step or a square-and-multiply power step per cycle.
module pee_alu
   import pee_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  alu_ctl_type ctl,
   input  logic [31:0] a,
   input  logic [31:0] b,
   output logic        done,
   output logic [31:0] result
);

   typedef enum logic [1:0] {A_IDLE, A_DIV, A_POW_M, A_POW_S} alu_state_type;

   alu_state_type state_ff, state_in;
   op_type        op_ff, op_in;
   logic [31:0]   acc_ff, acc_in;     // quotient or power accumulator
   logic [31:0]   rem_ff, rem_in;
   logic [31:0]   base_ff, base_in;   // divisor magnitude or power base
   logic [31:0]   expo_ff, expo_in;
   logic [5:0]    cnt_ff, cnt_in;
   logic          neg_q_ff, neg_q_in;
   logic          neg_r_ff, neg_r_in;
   logic          done_ff, done_in;
   logic [31:0]   res_ff, res_in;

   logic [32:0] trial;
   logic [31:0] rem_sh;
   logic [31:0] mag_a, mag_b, quo_next;
   logic [31:0] mul_x, mul_y;
   logic [63:0] prod;

   assign mag_a = a[31] ? 32'd0 - a : a;
   assign mag_b = b[31] ? 32'd0 - b : b;
   assign rem_sh = {rem_ff[30:0], acc_ff[31]};
   assign trial = {1'b0, rem_sh} - {1'b0, base_ff};
   assign quo_next = {acc_ff[30:0], ~trial[32]};

   // The single shared multiplier.
   always_comb begin
      mul_x = a;
      mul_y = b;
      if (state_ff == A_POW_M) begin
         mul_x = acc_ff;
         mul_y = base_ff;
      end else if (state_ff == A_POW_S) begin
         mul_x = base_ff;
         mul_y = base_ff;
      end
   end
   assign prod = mul_x * mul_y;

   always_comb begin
      state_in = state_ff;
      op_in    = op_ff;
      acc_in   = acc_ff;
      rem_in   = rem_ff;
      base_in  = base_ff;
      expo_in  = expo_ff;
      cnt_in   = cnt_ff;
      neg_q_in = neg_q_ff;
      neg_r_in = neg_r_ff;
      done_in  = 1'b0;
      res_in   = res_ff;
      unique case (state_ff)
         A_IDLE: begin
            if (ctl.start) begin
               op_in = ctl.op;
               unique case (ctl.op)
                  OP_ADD: begin res_in = a + b; done_in = 1'b1; end
                  OP_SUB: begin res_in = a - b; done_in = 1'b1; end
                  OP_MUL: begin res_in = prod[31:0]; done_in = 1'b1; end
                  OP_DIV, OP_REM: begin
                     acc_in   = mag_a;
                     rem_in   = 32'd0;
                     base_in  = mag_b;
                     cnt_in   = 6'd32;
                     neg_q_in = a[31] ^ b[31];
                     neg_r_in = a[31];
                     state_in = A_DIV;
                  end
                  OP_POW: begin
                     if (b[31] || b == 32'd0) begin
                        res_in  = 32'd1;
                        done_in = 1'b1;
                     end else begin
                        acc_in   = 32'd1;
                        base_in  = a;
                        expo_in  = b;
                        state_in = A_POW_M;
                     end
                  end
                  default: begin res_in = 32'd0; done_in = 1'b1; end
               endcase
            end
         end
         A_DIV: begin
            rem_in = trial[32] ? rem_sh : trial[31:0];
            acc_in = quo_next;
            cnt_in = cnt_ff - 6'd1;
            if (cnt_ff == 6'd1) begin
               if (op_ff == OP_DIV) begin
                  res_in = neg_q_ff ? 32'd0 - quo_next : quo_next;
               end else begin
                  res_in = neg_r_ff ? 32'd0 - rem_in : rem_in;
               end
               done_in  = 1'b1;
               state_in = A_IDLE;
            end
         end
         A_POW_M: begin
            if (expo_ff[0]) begin
               acc_in = prod[31:0];
            end
            expo_in = expo_ff >> 1;
            if (expo_ff[31:1] == 31'd0) begin
               res_in   = expo_ff[0] ? prod[31:0] : acc_ff;
               done_in  = 1'b1;
               state_in = A_IDLE;
            end else begin
               state_in = A_POW_S;
            end
         end
         A_POW_S: begin
            base_in  = prod[31:0];
            state_in = A_POW_M;
         end
         default: state_in = A_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= A_IDLE;
         done_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         done_ff  <= done_in;
      end
      op_ff    <= op_in;
      acc_ff   <= acc_in;
      rem_ff   <= rem_in;
      base_ff  <= base_in;
      expo_ff  <= expo_in;
      cnt_ff   <= cnt_in;
      neg_q_ff <= neg_q_in;
      neg_r_ff <= neg_r_in;
      res_ff   <= res_in;
   end

   assign done   = done_ff;
   assign result = res_ff;

endmodule

// ----- rtl/core/postfix_expression_evaluator_core.sv -----
// Channel | Direction | Handshake          | Payload
// req     | in        | req_valid/req_stall| req_symbol[7:0], req_last
// rsp     | out       | rsp_valid/rsp_stall| rsp_value[31:0] signed, rsp_status[2:0]
//
// A digit is pushed in the decode step; an operator also reads both operands,
// starts the one shared arithmetic unit and waits for its result, and ^ makes
// a multiply pass per exponent bit with a squaring pass between passes. A last
// character then reads the top entry and holds in the result state until the
// result transfer completes.
// Reset is synchronous and active high; it empties the stack and clears the
// error. The stack memory itself is not cleared. req_stall is high whenever
// an item is in flight or a result waits on rsp_stall.
module postfix_expression_evaluator_core
   import pee_pkg::*;
#(
   parameter int STACK_DEPTH = 128
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic [7:0]         req_symbol,
   input  logic               req_last,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic signed [31:0] rsp_value,
   output logic [2:0]         rsp_status
);

   localparam int AW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
   localparam int CW = $clog2(STACK_DEPTH + 1);

   // Operand stack memory: one write and one registered read port.
   logic [31:0] stack_mem [STACK_DEPTH];
   logic [31:0] rd_data_ff;
   logic [AW-1:0] rd_addr;
   logic          wr_en;
   logic [AW-1:0] wr_addr;
   logic [31:0]   wr_data;

   state_type   state_ff, state_in;
   logic [CW-1:0] count_ff, count_in;
   logic [2:0]  err_ff, err_in;
   logic [7:0]  sym_ff, sym_in;
   logic        last_ff, last_in;
   logic [31:0] b_ff, b_in;
   logic [31:0] a_ff, a_in;
   logic [31:0] val_ff, val_in;
   logic [2:0]  stat_ff, stat_in;

   alu_ctl_type alu_ctl;
   logic        alu_done;
   logic [31:0] alu_result;

   logic is_digit, is_op;
   op_type dec_op;

   assign is_digit = (sym_ff >= CHAR_ZERO) && (sym_ff <= CHAR_NINE);

   always_comb begin
      is_op  = 1'b1;
      dec_op = OP_ADD;
      priority case (sym_ff)
         CHAR_ADD: dec_op = OP_ADD;
         CHAR_SUB: dec_op = OP_SUB;
         CHAR_MUL: dec_op = OP_MUL;
         CHAR_DIV: dec_op = OP_DIV;
         CHAR_REM: dec_op = OP_REM;
         CHAR_POW: dec_op = OP_POW;
         default:  is_op  = 1'b0;
      endcase
   end

   // The unit samples its operands in the start cycle, when a is only just
   // arriving from the memory, so it sees the next value of the a register.
   pee_alu u_alu (
      .clock  (clock),
      .reset  (reset),
      .ctl    (alu_ctl),
      .a      (a_in),
      .b      (b_ff),
      .done   (alu_done),
      .result (alu_result)
   );

   // Next-state logic.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               state_in = S_RD_B;
            end
         end
         S_RD_B: begin
            // Decode step: decide what this character does.
            if (err_ff != ST_OK || !is_op || count_ff < CW'(2)) begin
               state_in = last_ff ? S_RD_WAIT : S_IDLE;
            end else begin
               state_in = S_RD_A;
            end
         end
         S_RD_A:   state_in = S_EXEC;
         S_EXEC:   state_in = S_WAIT;
         S_WAIT: begin
            if (alu_done) begin
               state_in = last_ff ? S_RD_WAIT : S_IDLE;
            end
         end
         S_RD_WAIT: state_in = S_RD_TOP;
         S_RD_TOP:  state_in = S_RESP;
         S_RESP: begin
            if (!rsp_stall) begin
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   // Output and datapath logic.
   always_comb begin
      count_in = count_ff;
      err_in   = err_ff;
      sym_in   = sym_ff;
      last_in  = last_ff;
      b_in     = b_ff;
      a_in     = a_ff;
      val_in   = val_ff;
      stat_in  = stat_ff;
      wr_en    = 1'b0;
      wr_addr  = count_ff[AW-1:0];
      wr_data  = {24'd0, sym_ff - CHAR_ZERO};
      rd_addr  = AW'(count_ff - CW'(1));
      alu_ctl.start = 1'b0;
      alu_ctl.op    = dec_op;
      unique case (state_ff)
         S_IDLE: begin
            sym_in  = req_symbol;
            last_in = req_last;
         end
         S_RD_B: begin
            // rd_addr presents the top entry (b).
            if (err_ff == ST_OK) begin
               if (is_digit) begin
                  if (count_ff >= CW'(STACK_DEPTH)) begin
                     err_in = ST_OVERFLOW;
                  end else begin
                     wr_en    = 1'b1;
                     count_in = count_ff + CW'(1);
                  end
               end else if (is_op) begin
                  if (count_ff < CW'(2)) begin
                     err_in = ST_UNDERFLOW;
                  end
               end else begin
                  err_in = ST_INVALID;
               end
            end
         end
         S_RD_A: begin
            rd_addr = AW'(count_ff - CW'(2));
         end
         S_EXEC: begin
            a_in = rd_data_ff;
            alu_ctl.start = 1'b1;
         end
         S_WAIT: begin
            rd_addr = AW'(count_ff - CW'(2));
            if (alu_done) begin
               if ((dec_op == OP_DIV || dec_op == OP_REM) && b_ff == 32'd0) begin
                  err_in = ST_ZERODIV;
               end else begin
                  wr_en    = 1'b1;
                  wr_addr  = AW'(count_ff - CW'(2));
                  wr_data  = alu_result;
                  count_in = count_ff - CW'(1);
               end
            end
         end
         S_RD_TOP: begin
            if (err_ff == ST_OK && count_ff == CW'(0)) begin
               stat_in = ST_UNDERFLOW;
               val_in  = 32'd0;
            end else if (err_ff != ST_OK) begin
               stat_in = err_ff;
               val_in  = 32'd0;
            end else begin
               stat_in = ST_OK;
               val_in  = rd_data_ff;
            end
            count_in = '0;
            err_in   = ST_OK;
         end
         S_RD_WAIT: begin
         end
         S_RESP: begin
         end
         default: begin
         end
      endcase
      if (state_ff == S_RD_A) begin
         b_in = rd_data_ff;
      end
   end

   // The top read for the final pop is issued in S_RD_WAIT, in the cycle after
   // the last push or result write, so rd_data_ff holds the top entry in
   // S_RD_TOP.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         stack_mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= stack_mem[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         count_ff <= '0;
         err_ff   <= ST_OK;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
         err_ff   <= err_in;
      end
      sym_ff  <= sym_in;
      last_ff <= last_in;
      b_ff    <= b_in;
      a_ff    <= a_in;
      val_ff  <= val_in;
      stat_ff <= stat_in;
   end

   assign req_stall  = (state_ff != S_IDLE);
   assign rsp_valid  = (state_ff == S_RESP);
   assign rsp_value  = val_ff;
   assign rsp_status = stat_ff;

endmodule

// ----- tb/sv/tb_postfix_expression_evaluator_core.sv -----
`timescale 1ns / 1ps

module tb_postfix_expression_evaluator_core;
   import pee_pkg::*;

   localparam int DEPTH = 128;
   localparam int IDLE_LIMIT = 20000;

   // Expected result of one expression.
   typedef struct {
      logic signed [31:0] value;
      logic [2:0]         status;
   } rpn_result_type;

   // Scoreboard: mirrors the operand stack and checks the result transfers in order.
   class rpn_scoreboard;
      logic [31:0]     stack_mem [DEPTH];
      int              depth_used;
      logic [2:0]      err;
      rpn_result_type  pending [$];
      int              failures;

      function new();
         depth_used = 0;
         err = ST_OK;
         failures = 0;
      endfunction

      function logic [31:0] pow_wrap(logic [31:0] base, logic [31:0] expo);
         logic [31:0] acc;
         acc = 32'd1;
         if (expo[31] || expo == 0) return 32'd1;
         while (expo != 0) begin
            if (expo[0]) acc = acc * base;
            base = base * base;
            expo = expo >> 1;
         end
         return acc;
      endfunction

      // Applies one character to the mirrored stack.
      function void apply_symbol(logic [7:0] c);
         logic [31:0] a, b, r, ma, mb;
         if (c >= CHAR_ZERO && c <= CHAR_NINE) begin
            if (depth_used >= DEPTH) begin
               err = ST_OVERFLOW;
               return;
            end
            stack_mem[depth_used] = {24'd0, c - CHAR_ZERO};
            depth_used++;
         end else if (c == CHAR_ADD || c == CHAR_SUB || c == CHAR_MUL ||
                      c == CHAR_DIV || c == CHAR_REM || c == CHAR_POW) begin
            if (depth_used < 2) begin
               err = ST_UNDERFLOW;
               return;
            end
            b = stack_mem[depth_used-1];
            a = stack_mem[depth_used-2];
            case (c)
               CHAR_ADD: r = a + b;
               CHAR_SUB: r = a - b;
               CHAR_MUL: r = a * b;
               CHAR_POW: r = pow_wrap(a, b);
               default: begin
                  if (b == 0) begin
                     err = ST_ZERODIV;
                     return;
                  end
                  ma = a[31] ? -a : a;
                  mb = b[31] ? -b : b;
                  if (c == CHAR_DIV) r = (a[31] != b[31]) ? -(ma / mb) : ma / mb;
                  else r = a[31] ? -(ma % mb) : ma % mb;
               end
            endcase
            depth_used--;
            stack_mem[depth_used-1] = r;
         end else begin
            err = ST_INVALID;
         end
      endfunction

      // Notes one accepted input transfer.
      function void note_symbol(logic [7:0] c, logic fin);
         rpn_result_type e;
         if (err == ST_OK) apply_symbol(c);
         if (!fin) return;
         e.value = 0;
         if (err == ST_OK) begin
            if (depth_used == 0) err = ST_UNDERFLOW;
            else e.value = stack_mem[depth_used-1];
         end
         if (err != ST_OK) e.value = 0;
         e.status = err;
         pending.push_back(e);
         depth_used = 0;
         err = ST_OK;
      endfunction

      // Checks one accepted result transfer against the oldest expectation.
      function void check_result(logic signed [31:0] v, logic [2:0] s);
         rpn_result_type e;
         if (pending.size() == 0) begin
            $display("%0t: unexpected result value=%0d status=%0d", $time, v, s);
            failures++;
            return;
         end
         e = pending.pop_front();
         if (v !== e.value) begin
            $display("%0t: value mismatch expected=%0d actual=%0d", $time, e.value, v);
            failures++;
         end
         if (s !== e.status) begin
            $display("%0t: status mismatch expected=%0d actual=%0d", $time, e.status, s);
            failures++;
         end
      endfunction
   endclass

   logic               clock;
   logic               reset;
   logic               req_valid;
   logic               req_stall;
   logic [7:0]         req_symbol;
   logic               req_last;
   logic               rsp_valid;
   logic               rsp_stall;
   logic signed [31:0] rsp_value;
   logic [2:0]         rsp_status;

   rpn_scoreboard sb;
   bit   quiet_phase;   // No idling on either side in the last part of the run.
   bit   hold_rsp;      // Long receiver hold-off to back the block up.
   int   idle_cycles;

   postfix_expression_evaluator_core #(.STACK_DEPTH(DEPTH)) u_top (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_stall  (req_stall),
      .req_symbol (req_symbol),
      .req_last   (req_last),
      .rsp_valid  (rsp_valid),
      .rsp_stall  (rsp_stall),
      .rsp_value  (rsp_value),
      .rsp_status (rsp_status)
   );

   always begin
      clock = 1'b1;
      #10;
      clock = 1'b0;
      #10;
   end

   // Both transfers are observed at the rising edge, from values settled before it.
   always @(posedge clock) begin
      if (!reset) begin
         if (req_valid && !req_stall) sb.note_symbol(req_symbol, req_last);
         if (rsp_valid && !rsp_stall) sb.check_result(rsp_value, rsp_status);
      end
   end

   // Watchdog: counts cycles in which no transfer completes on either side.
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
         if (idle_cycles >= IDLE_LIMIT) begin
            $display("** postfix_expression_evaluator_core: FAILED **");
            $finish;
         end
      end
   end

   // Receiver: random stall bursts, plus one long hold-off when asked.
   initial begin : receiver
      int n;
      bit held;
      held = 1'b0;
      rsp_stall = 1'b1;
      @(posedge clock);
      while (reset) @(posedge clock);
      forever begin
         if (hold_rsp && !held) begin
            rsp_stall <= 1'b1;
            for (n = 0; n < 600; n++) @(posedge clock);
            held = 1'b1;
         end else if (!quiet_phase && $urandom_range(0, 3) == 0) begin
            rsp_stall <= 1'b1;
            n = $urandom_range(1, 18);
            repeat (n) @(posedge clock);
         end else begin
            rsp_stall <= 1'b0;
            n = $urandom_range(1, 30);
            repeat (n) @(posedge clock);
         end
      end
   end

   // Offers one character and holds it until it is accepted.
   task automatic send_symbol(input logic [7:0] c, input logic fin);
      int gap;
      if (!quiet_phase && $urandom_range(0, 4) == 0) begin
         req_valid <= 1'b0;
         gap = $urandom_range(1, 18);
         repeat (gap) @(posedge clock);
      end
      req_valid  <= 1'b1;
      req_symbol <= c;
      req_last   <= fin;
      @(posedge clock);
      while (req_stall) @(posedge clock);
   endtask

   function automatic logic [7:0] pick_digit();
      return CHAR_ZERO + 8'($urandom_range(0, 9));
   endfunction

   function automatic logic [7:0] pick_operator();
      case ($urandom_range(0, 5))
         0: return CHAR_ADD;
         1: return CHAR_SUB;
         2: return CHAR_MUL;
         3: return CHAR_DIV;
         4: return CHAR_REM;
         default: return CHAR_POW;
      endcase
   endfunction

   // Sends a well-formed expression with random content, sometimes broken.
   task automatic send_expression(inout int sent);
      int n_ops, live, k;
      logic [7:0] c;
      n_ops = $urandom_range(0, 8);
      send_symbol(pick_digit(), n_ops == 0);
      sent++;
      live = 1;
      k = 0;
      while (k < n_ops) begin
         if ($urandom_range(0, 40) == 0) c = 8'($urandom_range(0, 255));
         else if (live < 2 || $urandom_range(0, 2) == 0) c = pick_digit();
         else c = pick_operator();
         if (c >= CHAR_ZERO && c <= CHAR_NINE) live++;
         else begin
            live = (live > 1) ? live - 1 : live;
            k++;
         end
         send_symbol(c, k == n_ops && live == 1 ? 1'b1 : 1'b0);
         sent++;
         if (k == n_ops && live != 1) begin
            // Leftover entries: close with an operator anyway.
            send_symbol(pick_operator(), 1'b1);
            sent++;
         end
      end
   endtask

   task automatic send_string(input string s);
      int i;
      for (i = 0; i < s.len(); i++) send_symbol(s[i], i == s.len() - 1);
   endtask

   initial begin : stimulus
      int sent, i;
      sb = new();
      reset = 1'b1;
      req_valid = 1'b0;
      req_symbol = 8'd0;
      req_last = 1'b0;
      quiet_phase = 1'b0;
      hold_rsp = 1'b0;
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed: every operator, truncation signs, most negative over minus one,
      // zero divisor, underflow, invalid characters at both ends, power corners.
      send_string("93+");
      send_string("09-");
      send_string("09-4/");
      send_string("09-4%");
      send_string("72*");
      send_string("29^");
      send_string("20^");
      send_string("209-^");
      send_string("50/");
      send_string("50%");
      send_string("5+");
      send_string("");
      send_symbol(8'h00, 1'b1);
      send_symbol(8'hFF, 1'b1);
      send_string("8");
      send_string("12");
      send_string("2 3");
      send_string("29^99*^");
      send_string("239*4+^01-/");        // 2^31 wraps to most negative, / -1 wraps
      send_string("239*4+^01-%");
      send_symbol(CHAR_ADD, 1'b1);       // operator on an empty stack gives underflow
      sent = 0;

      // Overflow: fill the stack past its depth once.
      for (i = 0; i <= DEPTH; i++) send_symbol(pick_digit(), i == DEPTH);

      // Back the block up while the sender keeps offering.
      hold_rsp = 1'b1;
      while (sent < 300) send_expression(sent);
      while (sent < 570) begin
         if ($urandom_range(0, 9) == 0) begin
            send_symbol(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
            sent++;
         end else begin
            send_expression(sent);
         end
      end
      quiet_phase = 1'b1;
      while (sent < 760) send_expression(sent);
      req_valid <= 1'b0;

      while (sb.pending.size() != 0) @(posedge clock);
      repeat (100) @(posedge clock);
      if (sb.failures == 0 && sb.pending.size() == 0)
         $display("** postfix_expression_evaluator_core: PASSED **");
      else
         $display("** postfix_expression_evaluator_core: FAILED **");
      $finish;
   end

endmodule

// ----- filelist.f -----
rtl/core/pee_pkg.sv
rtl/core/pee_alu.sv
rtl/core/postfix_expression_evaluator_core.sv
tb/sv/tb_postfix_expression_evaluator_core.sv
